// ----- hdl/tspg_pkg.sv -----
// ----------------------------------------------------------------------------
// tspg_pkg: shared definitions for the three-axis step pulse generator
// Default widths, register reset values, operation and register codes.
// ----------------------------------------------------------------------------
package tspg_pkg;

    localparam int POSITION_BITS_DEF = 18;
    localparam int PERIOD_BITS_DEF   = 20;
    localparam int RATE_BITS         = 8;
    localparam int AXES              = 3;

    localparam int RATE_RST   = 4;
    localparam int HOME_A_RST = 1217;
    localparam int HOME_B_RST = 20945;
    localparam int HOME_C_RST = -36776;

    // Period of an axis that does not move in a move word
    localparam int IDLE_PERIOD = 2;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_HOME = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_RATE   = 2'd0,
        CFG_HOME_A = 2'd1,
        CFG_HOME_B = 2'd2,
        CFG_HOME_C = 2'd3
    } t_cfg_index;

endpackage

// ----- hdl/three_axis_step_pulse_generator_unit.sv -----
// ----------------------------------------------------------------------------
// three_axis_step_pulse_generator_unit: three-axis stepper step generator
// Tracks positions in steps, plans per-axis pulse periods with one shared
// serial divider and steps each axis on tick words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word: an operation
//   (tick, move, home) and three goal positions used by a move. Every word
//   returns exactly one result word on the output channel (o_out_valid /
//   i_out_ready) with pin levels, directions, moving flags and positions,
//   taken after the word has acted.
//   Steps per word (from its acceptance to its result):
//     tick: each axis in turn through the shared counter/compare.
//     home, unknown code, move before homing: result flagged on acceptance.
//     move: a difference per axis, a commit, then per axis a load and,
//     for a nonzero delta, the serial divide (one quotient bit a cycle)
//     and a saturate step.
//   Configuration writes (i_cfg_we) are registered and are meant for
//   idle periods only.
//   Reset (synchronous, active low) clears positions, counts, counters,
//   periods, pins and the homed flag; direction of axis three is positive.
//   A stalled receiver holds the result word; the next input word is still
//   taken, but its result waits, held by the pending flag in the idle state,
//   until the output register frees.
// ----------------------------------------------------------------------------
module three_axis_step_pulse_generator_unit #(
    parameter int POSITION_BITS = tspg_pkg::POSITION_BITS_DEF,
    parameter int PERIOD_BITS   = tspg_pkg::PERIOD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [((POSITION_BITS > tspg_pkg::RATE_BITS) ? POSITION_BITS
                   : tspg_pkg::RATE_BITS)-1:0] i_cfg_data,
    // input words
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_operation,
    input  logic signed [POSITION_BITS-1:0] i_goal_a,
    input  logic signed [POSITION_BITS-1:0] i_goal_b,
    input  logic signed [POSITION_BITS-1:0] i_goal_c,
    // result words
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_pulse_levels,
    output logic [2:0]                      o_direction_bits,
    output logic [2:0]                      o_moving_bits,
    output logic signed [POSITION_BITS-1:0] o_position_a,
    output logic signed [POSITION_BITS-1:0] o_position_b,
    output logic signed [POSITION_BITS-1:0] o_position_c
);

    localparam int P     = POSITION_BITS;
    localparam int RB    = tspg_pkg::RATE_BITS;
    localparam int DW    = RB + P;                       // dividend / quotient width
    localparam int BIT_W = $clog2(DW);
    localparam int CW    = (DW + 1 > PERIOD_BITS) ? DW + 1 : PERIOD_BITS;

    localparam logic [1:0] AXIS_FIRST = 2'd0;
    localparam logic [1:0] AXIS_LAST  = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_TICK   = 7'b0000010,
        S_DIFF   = 7'b0000100,
        S_COMMIT = 7'b0001000,
        S_DLOAD  = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_SAT    = 7'b1000000
    } t_state;

    // Done step shares the idle state: a flag marks a result to publish
    logic                  r_pend, n_pend;
    t_state                r_state, n_state;
    logic [1:0]            r_axis, n_axis;

    logic [RB-1:0]         r_rate;
    logic [P-1:0]          r_home [3];

    logic [P-1:0]          r_goal [3], n_goal [3];
    logic [P-1:0]          r_pos [3], n_pos [3];
    logic [P-1:0]          r_count [3], n_count [3];
    logic [PERIOD_BITS-1:0] r_tick [3], n_tick [3];
    logic [PERIOD_BITS-1:0] r_period [3], n_period [3];
    logic [2:0]            r_dir, n_dir;
    logic [2:0]            r_pin, n_pin;
    logic                  r_homed, n_homed;

    logic [P-1:0]          r_mag [3], n_mag [3];
    logic [2:0]            r_dneg, n_dneg;
    logic [2:0]            r_dzero, n_dzero;
    logic [P-1:0]          r_longest, n_longest;

    logic [DW-1:0]         r_prod, n_prod;
    logic [DW-1:0]         r_quo, n_quo;
    logic [P-1:0]          r_rem, n_rem;
    logic [P-1:0]          r_divisor, n_divisor;
    logic [BIT_W-1:0]      r_bit, n_bit;

    logic                  r_out_valid, n_out_valid;
    logic [2:0]            r_out_pulse, n_out_pulse;
    logic [2:0]            r_out_dir, n_out_dir;
    logic [2:0]            r_out_moving, n_out_moving;
    logic [P-1:0]          r_out_pos [3], n_out_pos [3];

    // shared datapath signals
    logic [PERIOD_BITS-1:0] w_cnt_inc;
    logic                   w_hit;
    logic signed [P:0]      w_diff;
    logic [P:0]             w_abs;
    logic [P:0]             w_trial_in;
    logic [P:0]             w_trial;
    logic [CW-1:0]          w_q2;
    logic [CW-1:0]          w_per_max;
    logic                   w_accept;
    logic                   w_pub;
    logic [2:0]             w_moving;

    assign o_in_ready = (r_state == S_IDLE) && !r_pend;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pub      = r_pend && (!r_out_valid || i_out_ready);

    assign w_cnt_inc  = r_tick[r_axis] + PERIOD_BITS'(1);
    assign w_hit      = (w_cnt_inc >= r_period[r_axis]);

    assign w_diff     = $signed({r_goal[r_axis][P-1], r_goal[r_axis]})
                      - $signed({r_pos[r_axis][P-1], r_pos[r_axis]});
    assign w_abs      = w_diff[P] ? (-w_diff) : w_diff;

    assign w_trial_in = {r_rem, r_quo[DW-1]};
    assign w_trial    = w_trial_in - {1'b0, r_divisor};

    assign w_q2       = CW'(r_quo) + CW'(tspg_pkg::IDLE_PERIOD);
    assign w_per_max  = CW'({PERIOD_BITS{1'b1}});

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_moving[k] = (r_count[k] != '0);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_axis      = r_axis;
        n_goal      = r_goal;
        n_pos       = r_pos;
        n_count     = r_count;
        n_tick      = r_tick;
        n_period    = r_period;
        n_dir       = r_dir;
        n_pin       = r_pin;
        n_homed     = r_homed;
        n_mag       = r_mag;
        n_dneg      = r_dneg;
        n_dzero     = r_dzero;
        n_longest   = r_longest;
        n_prod      = r_prod;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_divisor   = r_divisor;
        n_bit       = r_bit;
        n_out_valid = r_out_valid;
        n_out_pulse = r_out_pulse;
        n_out_dir   = r_out_dir;
        n_out_moving = r_out_moving;
        n_out_pos   = r_out_pos;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // publish the finished word once the output register is free
        if (w_pub) begin
            n_pend       = 1'b0;
            n_out_valid  = 1'b1;
            n_out_pulse  = r_pin;
            n_out_dir    = r_dir;
            n_out_moving = w_moving;
            n_out_pos    = r_pos;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_goal[0] = i_goal_a;
                    n_goal[1] = i_goal_b;
                    n_goal[2] = i_goal_c;
                    n_axis    = AXIS_FIRST;
                    case (i_operation)
                        tspg_pkg::OP_TICK: begin
                            n_state = S_TICK;
                        end
                        tspg_pkg::OP_MOVE: begin
                            if (r_homed) begin
                                n_longest = '0;
                                n_state   = S_DIFF;
                            end else begin
                                n_pend = 1'b1;
                            end
                        end
                        tspg_pkg::OP_HOME: begin
                            n_pos   = r_home;
                            n_homed = 1'b1;
                            n_pend  = 1'b1;
                        end
                        default: begin
                            n_pend = 1'b1;
                        end
                    endcase
                end
            end

            S_TICK: begin
                if (r_count[r_axis] != '0) begin
                    if (w_hit) begin
                        n_pin[r_axis]   = ~r_pin[r_axis];
                        n_tick[r_axis]  = '0;
                        n_count[r_axis] = r_count[r_axis] - P'(1);
                        n_pos[r_axis]   = r_dir[r_axis] ? (r_pos[r_axis] + P'(1))
                                                        : (r_pos[r_axis] - P'(1));
                        // axis two drags axis three the opposite way
                        if (r_axis == 2'd1) begin
                            n_pos[2] = r_dir[1] ? (r_pos[2] - P'(1)) : (r_pos[2] + P'(1));
                        end
                    end else begin
                        n_tick[r_axis] = w_cnt_inc;
                    end
                end else begin
                    n_pin[r_axis] = 1'b0;
                end
                if (r_axis == AXIS_LAST) begin
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end

            S_DIFF: begin
                n_mag[r_axis]   = w_abs[P-1:0];
                n_dneg[r_axis]  = w_diff[P];
                n_dzero[r_axis] = (w_diff == '0);
                if (w_abs[P-1:0] > r_longest) begin
                    n_longest = w_abs[P-1:0];
                end
                if (r_axis == AXIS_LAST) begin
                    n_state = S_COMMIT;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end

            S_COMMIT: begin
                n_dir[0] = !r_dneg[0] && !r_dzero[0];
                n_dir[1] = !r_dneg[1];
                n_dir[2] = (!r_dneg[2] && !r_dzero[2]) || (r_dzero[2] && !r_dneg[1]);
                n_count[0] = r_mag[0];
                n_count[1] = r_mag[1];
                // an axis three goal equal to its position keeps the count
                if (!r_dzero[2]) begin
                    n_count[2] = r_mag[2];
                end
                n_prod  = DW'(r_rate) * DW'(r_longest);
                n_axis  = AXIS_FIRST;
                n_state = S_DLOAD;
            end

            S_DLOAD: begin
                if (r_mag[r_axis] == '0) begin
                    n_period[r_axis] = PERIOD_BITS'(tspg_pkg::IDLE_PERIOD);
                    if (r_axis == AXIS_LAST) begin
                        n_pend  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    n_rem     = '0;
                    n_quo     = r_prod;
                    n_divisor = r_mag[r_axis];
                    n_bit     = '0;
                    n_state   = S_DIV;
                end
            end

            S_DIV: begin
                // one restoring step: shift in a dividend bit, try a subtract
                if (w_trial[P]) begin
                    n_rem = w_trial_in[P-1:0];
                end else begin
                    n_rem = w_trial[P-1:0];
                end
                n_quo = {r_quo[DW-2:0], ~w_trial[P]};
                n_bit = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(DW - 1)) begin
                    n_state = S_SAT;
                end
            end

            S_SAT: begin
                n_period[r_axis] = (w_q2 > w_per_max) ? {PERIOD_BITS{1'b1}}
                                                     : w_q2[PERIOD_BITS-1:0];
                if (r_axis == AXIS_LAST) begin
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_DLOAD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_axis      <= AXIS_FIRST;
            r_dir       <= 3'b100;
            r_pin       <= '0;
            r_homed     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k]    <= '0;
                r_count[k]  <= '0;
                r_tick[k]   <= '0;
                r_period[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_axis      <= n_axis;
            r_dir       <= n_dir;
            r_pin       <= n_pin;
            r_homed     <= n_homed;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_tick      <= n_tick;
            r_period    <= n_period;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= RB'(tspg_pkg::RATE_RST);
            r_home[0] <= P'(tspg_pkg::HOME_A_RST);
            r_home[1] <= P'(tspg_pkg::HOME_B_RST);
            r_home[2] <= P'(tspg_pkg::HOME_C_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tspg_pkg::CFG_RATE:   r_rate    <= i_cfg_data[RB-1:0];
                tspg_pkg::CFG_HOME_A: r_home[0] <= i_cfg_data[P-1:0];
                tspg_pkg::CFG_HOME_B: r_home[1] <= i_cfg_data[P-1:0];
                tspg_pkg::CFG_HOME_C: r_home[2] <= i_cfg_data[P-1:0];
                default: r_rate <= r_rate;
            endcase
        end
    end

    // working payload, no reset
    always_ff @(posedge i_clk) begin
        r_goal       <= n_goal;
        r_mag        <= n_mag;
        r_dneg       <= n_dneg;
        r_dzero      <= n_dzero;
        r_longest    <= n_longest;
        r_prod       <= n_prod;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_divisor    <= n_divisor;
        r_bit        <= n_bit;
        r_out_pulse  <= n_out_pulse;
        r_out_dir    <= n_out_dir;
        r_out_moving <= n_out_moving;
        r_out_pos    <= n_out_pos;
    end

    assign o_out_valid      = r_out_valid;
    assign o_pulse_levels   = r_out_pulse;
    assign o_direction_bits = r_out_dir;
    assign o_moving_bits    = r_out_moving;
    assign o_position_a     = r_out_pos[0];
    assign o_position_b     = r_out_pos[1];
    assign o_position_c     = r_out_pos[2];

endmodule
